### hw/rtl/ucolb_pkg.sv
// ----------------------------------------------------------------------------
// Unique colour table builder - shared definitions
// Constants, field positions and the token type that walks the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucolb_pkg;

  // default number of table entries (one cell each)
  localparam int TABLE_DEPTH_DEF = 256;

  // channel value that means fully opaque
  localparam logic [7:0] OPAQUE = 8'hFF;

  // channel mask bit positions
  localparam int MASK_RED_BIT   = 0;
  localparam int MASK_GREEN_BIT = 1;
  localparam int MASK_BLUE_BIT  = 2;
  localparam int MASK_ALPHA_BIT = 3;

  // stream widths
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 24;
  localparam int KEY_W    = 32;

  // request travelling down the chain; the index rides alongside
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [KEY_W-1:0] key;
  } token_t;

endpackage

`default_nettype wire

### hw/rtl/ucolb_cell.sv
// ----------------------------------------------------------------------------
// Unique colour table builder - table cell
// Holds one colour entry, checks the passing request against it and stores
// the colour when the request reaches the first free slot without a hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucolb_cell #(
  parameter int TABLE_DEPTH = ucolb_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX       = 0
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [$clog2(TABLE_DEPTH+1)-1:0]     count,
  input  ucolb_pkg::token_t                    tin,
  input  wire  [$clog2(TABLE_DEPTH)-1:0]       idx_in,
  output ucolb_pkg::token_t                    tout,
  output logic [$clog2(TABLE_DEPTH)-1:0]       idx_out
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH+1);

  logic [ucolb_pkg::KEY_W-1:0] entry;
  logic                        occupied;
  logic                        match;
  logic                        insert;

  // entry is live only while this slot lies below the fill count
  assign occupied = (CNT_W'(INDEX) < count);
  assign match    = tin.valid && !tin.hit && occupied && (entry == tin.key);
  assign insert   = tin.valid && !tin.hit && (count == CNT_W'(INDEX));

  // stored colour
  always_ff @(posedge clk) begin
    if (insert) begin
      entry <= tin.key;
    end
  end

  // pass the request on
  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
    end
    tout.key <= tin.key;
    tout.hit <= tin.hit | match;
    idx_out  <= match ? IDX_W'(INDEX) : idx_in;
  end

endmodule

`default_nettype wire

### hw/rtl/ucolb_ctrl.sv
// ----------------------------------------------------------------------------
// Unique colour table builder - controller
// Takes pixels in, launches them down the cell chain, settles count and
// overflow when the request leaves the chain and drives the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucolb_ctrl #(
  parameter int TABLE_DEPTH = ucolb_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire                                   cfg_wdata,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire  [ucolb_pkg::S_DATA_W-1:0]        s_tdata,
  input  wire  [ucolb_pkg::S_USER_W-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [ucolb_pkg::M_DATA_W-1:0]        m_tdata,
  output ucolb_pkg::token_t                     launch,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      count,
  input  ucolb_pkg::token_t                     exit_tok,
  input  wire  [$clog2(TABLE_DEPTH)-1:0]        exit_idx
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH+1);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t     state;
  logic       has_alpha;
  logic       overflow;
  logic [3:0] mask;

  // result waiting to move into the output register
  logic [IDX_W-1:0] res_idx;
  logic             res_new;

  // front end
  logic                        sop;
  logic [7:0]                  alpha_eff;
  logic [ucolb_pkg::KEY_W-1:0] key;
  logic [3:0]                  mask_next;

  // back end
  logic             full;
  logic [CNT_W-1:0] count_next;
  logic             overflow_next;
  logic [IDX_W-1:0] idx_next;
  logic             new_next;
  logic             out_load;

  assign s_tready = (state == IDLE);

  // output register free or emptying this cycle
  assign out_load = (state == DONE) && (!m_tvalid || m_tready);

  // key and channel mask of the incoming pixel
  always_comb begin
    sop       = s_tuser[0];
    alpha_eff = has_alpha ? s_tdata[31:24] : ucolb_pkg::OPAQUE;
    key       = {alpha_eff, s_tdata[23:0]};
    mask_next = sop ? 4'b0000 : mask;
    if (s_tdata[7:0] != 8'd0)   mask_next[ucolb_pkg::MASK_RED_BIT]   = 1'b1;
    if (s_tdata[15:8] != 8'd0)  mask_next[ucolb_pkg::MASK_GREEN_BIT] = 1'b1;
    if (s_tdata[23:16] != 8'd0) mask_next[ucolb_pkg::MASK_BLUE_BIT]  = 1'b1;
    if (alpha_eff != ucolb_pkg::OPAQUE) mask_next[ucolb_pkg::MASK_ALPHA_BIT] = 1'b1;
  end

  // outcome once the request has seen every cell
  always_comb begin
    full          = (count == CNT_W'(TABLE_DEPTH));
    count_next    = count;
    overflow_next = overflow;
    idx_next      = '0;
    new_next      = 1'b0;
    priority if (exit_tok.hit) begin
      idx_next = exit_idx;
    end else if (!full) begin
      idx_next   = count[IDX_W-1:0];
      new_next   = 1'b1;
      count_next = count + CNT_W'(1);
    end else begin
      overflow_next = 1'b1;
    end
  end

  // sequencer, table state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      has_alpha    <= 1'b1;
      overflow     <= 1'b0;
      mask         <= 4'b0000;
      count        <= '0;
      launch.valid <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        has_alpha <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          launch.valid <= s_tvalid;
          if (s_tvalid) begin
            if (sop) begin
              count    <= '0;
              overflow <= 1'b0;
            end
            mask         <= mask_next;
            launch.hit   <= 1'b0;
            launch.key   <= key;
            state        <= RUN;
          end
        end
        RUN: begin
          launch.valid <= 1'b0;
          if (exit_tok.valid) begin
            count    <= count_next;
            overflow <= overflow_next;
            res_idx  <= idx_next;
            res_new  <= new_next;
            state    <= DONE;
          end
        end
        DONE: begin
          if (out_load) begin
            m_tdata  <= {1'b0, mask, overflow, 9'(count), res_new, 8'(res_idx)};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/unique_colour_table_builder.sv
// ----------------------------------------------------------------------------
// Unique colour table builder
// Builds the table of distinct colours of an image, one pixel per request.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels arrive on the s_ stream; tuser[0] flags the first pixel of an
//   image and clears table, count, overflow flag and channel mask first.
//   One result per pixel leaves on the m_ stream: colour index, new flag,
//   distinct count, overflow flag and channels-in-use mask.
//   The user must set has_alpha through cfg_we/cfg_wdata only while the
//   block is idle; the block itself does not enforce this. 0 treats
//   pixels as RGB with alpha forced to 255. Each pixel walks a chain of
//   TABLE_DEPTH cells, one cell per cycle, each cell holding one stored
//   colour. The result is registered in the controller as the request
//   leaves the chain and then moves into the output register.
//   A pixel is taken while the previous result still waits in the output
//   register; a stalled receiver then holds the next result in the
//   controller and s_tready stays low until it moves on.
//   Reset (rst, synchronous) empties the table, sets has_alpha to 1 and
//   drops both valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unique_colour_table_builder #(
  parameter int TABLE_DEPTH = ucolb_pkg::TABLE_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire                              cfg_wdata,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  wire  [ucolb_pkg::S_DATA_W-1:0]   s_tdata,
  // start_of_image[0]
  input  wire  [ucolb_pkg::S_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // colour_index[7:0], is_new[8], distinct_count[17:9], table_overflow[18],
  // channels_used[22:19], zero[23]
  output logic [ucolb_pkg::M_DATA_W-1:0]   m_tdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH+1);

  ucolb_pkg::token_t tok [0:TABLE_DEPTH];
  logic [IDX_W-1:0]  idx [0:TABLE_DEPTH];
  logic [CNT_W-1:0]  count;

  // controller
  ucolb_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .launch    (tok[0]),
    .count     (count),
    .exit_tok  (tok[TABLE_DEPTH]),
    .exit_idx  (idx[TABLE_DEPTH])
  );

  assign idx[0] = '0;

  // chain of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ucolb_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX       (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .tin     (tok[i]),
      .idx_in  (idx[i]),
      .tout    (tok[i+1]),
      .idx_out (idx[i+1])
    );
  end

endmodule

`default_nettype wire

### hw/rtl/ucolb_checker.sv
// ----------------------------------------------------------------------------
// Unique colour table builder - port checker
// Concurrent checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucolb_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_tvalid,
  input wire                            s_tready,
  input wire                            m_tvalid,
  input wire                            m_tready,
  input wire [ucolb_pkg::M_DATA_W-1:0]  m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one pixel in the chain at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second pixel taken while busy");

  // a new colour lands at the last slot of the count
  a_new_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'(m_tdata[17:9] - 9'd1))
    else $error("new colour index does not follow count");

  // nothing is inserted once the table has overflowed
  a_new_no_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> !m_tdata[18])
    else $error("insert reported with overflow set");

endmodule

bind unique_colour_table_builder ucolb_checker u_ucolb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
